### hdl/ccm_pkg.sv
`timescale 1ns / 1ps

package ccm_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned RA_W        = 29;
  localparam int unsigned DEC_W       = 28;
  localparam int unsigned ENTRY_CNT_W = 15;
  localparam int unsigned THR_W       = 40;
  localparam int unsigned ENTRY_W     = RA_W + DEC_W;

  // Distance arithmetic widths
  localparam int unsigned SQ_RA_W  = 2 * RA_W;
  localparam int unsigned SQ_DEC_W = 2 * DEC_W;
  localparam int unsigned RSQ_W    = SQ_RA_W + 1;

  // Configuration port
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 64;
  localparam int unsigned REG_IDX_BIT = 3;
  localparam logic        REG_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(10000);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_DEPTH);

  // Item operations
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

endpackage

### hdl/ccm_ram.sv
`timescale 1ns / 1ps

module ccm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/coordinate_cross_match_unit.sv
`timescale 1ns / 1ps

// Positional cross-match unit. Holds up to ccm_pkg::TABLE_DEPTH reference
// positions (RA and signed Dec in microdegrees) in one single-port-read RAM.
// func 0 clears the table and func 1 appends one position (refused and
// flagged when full); both raise out_valid_o at the input transfer edge
// itself. func 2 queries: the stored entries are read one per cycle
// through the RAM read port into a three-stage distance pipeline (absolute
// differences, squares, sum and compare against the threshold register),
// and a query raises out_valid_o once every stored entry has passed the
// compare stage and the output register is free. One item is worked on
// at a time; the next input is taken once the output register is empty or
// its result transfers in the same cycle. The table needs no clearing pass
// after reset. The threshold register sits at byte address 0 of the APB port.
module coordinate_cross_match_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             func_i,
  input  logic [ccm_pkg::RA_W-1:0]               coord_ra_i,
  input  logic signed [ccm_pkg::DEC_W-1:0]       coord_dec_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   is_match_o,
  output logic                                   load_rejected_o,
  output logic [ccm_pkg::ENTRY_CNT_W-1:0]        entry_count_o,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ccm_pkg::APB_AW-1:0]             paddr,
  input  logic [ccm_pkg::APB_DW-1:0]             pwdata,
  output logic [ccm_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [ccm_pkg::COUNT_W-1:0]         count_q, count_d;
  logic [ccm_pkg::COUNT_W-1:0]         issue_q, issue_d;
  logic [ccm_pkg::THR_W-1:0]           thr_q;
  logic                                hit_q, hit_d;
  logic [ccm_pkg::RA_W-1:0]            qra_q;
  logic [ccm_pkg::DEC_W-1:0]           qdec_q;
  logic                                in_acc, out_acc, out_free, cfg_wr;

  // Output register
  logic                                out_valid_q, out_valid_d;
  logic                                out_load;
  logic                                res_match, res_rej;
  logic [ccm_pkg::COUNT_W-1:0]         res_count;
  logic                                out_match_q, out_rej_q;
  logic [ccm_pkg::COUNT_W-1:0]         out_count_q;

  // RAM access
  logic                                ram_we, ram_re;
  logic [ccm_pkg::ENTRY_W-1:0]         ram_rdata;
  logic [ccm_pkg::RA_W-1:0]            rd_ra;
  logic [ccm_pkg::DEC_W-1:0]           rd_dec;

  // Distance pipeline
  logic                                s1_valid_q, s2_valid_q, s3_valid_q;
  logic [ccm_pkg::RA_W-1:0]            dr_d, dr_q;
  logic signed [ccm_pkg::DEC_W:0]      dec_diff;
  logic [ccm_pkg::DEC_W:0]             dd_full;
  logic [ccm_pkg::DEC_W-1:0]           dd_q;
  logic [ccm_pkg::SQ_RA_W-1:0]         sq_ra_q;
  logic [ccm_pkg::SQ_DEC_W-1:0]        sq_dec_q;
  logic [ccm_pkg::RSQ_W-1:0]           rsq;
  logic                                below;

  // Handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[ccm_pkg::REG_IDX_BIT] == ccm_pkg::REG_THRESHOLD) ?
                  ccm_pkg::APB_DW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ccm_pkg::THR_RESET;
    end else if (cfg_wr && (paddr[ccm_pkg::REG_IDX_BIT] == ccm_pkg::REG_THRESHOLD)) begin
      thr_q <= pwdata[ccm_pkg::THR_W-1:0];
    end
  end

  // Reference table: RA in the upper bits, Dec in the lower bits
  ccm_ram #(
    .WIDTH (ccm_pkg::ENTRY_W),
    .DEPTH (ccm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ccm_pkg::ADDR_W-1:0]),
    .wdata_i ({coord_ra_i, coord_dec_i}),
    .re_i    (ram_re),
    .raddr_i (issue_q[ccm_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ra  = ram_rdata[ccm_pkg::ENTRY_W-1:ccm_pkg::DEC_W];
  assign rd_dec = ram_rdata[ccm_pkg::DEC_W-1:0];

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    hit_d     = hit_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    res_match = 1'b0;
    res_rej   = 1'b0;
    res_count = count_q;

    // fold in the compare stage
    if (s3_valid_q && below) begin
      hit_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_i)
            ccm_pkg::FUNC_CLEAR: begin
              count_d   = '0;
              res_count = '0;
              out_load  = 1'b1;
            end
            ccm_pkg::FUNC_APPEND: begin
              if (count_q < ccm_pkg::DEPTH_CNT) begin
                ram_we    = 1'b1;
                count_d   = count_q + 1'b1;
                res_count = count_q + 1'b1;
              end else begin
                res_rej = 1'b1;
              end
              out_load = 1'b1;
            end
            ccm_pkg::FUNC_QUERY: begin
              issue_d = '0;
              hit_d   = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_q < count_q) begin
          ram_re  = 1'b1;
          issue_d = issue_q + 1'b1;
        end else if (!s1_valid_q && !s2_valid_q && !s3_valid_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_match = hit_q;
          out_load  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= ram_re;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
    end
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q <= res_match;
      out_rej_q   <= res_rej;
      out_count_q <= res_count;
    end
    if (in_acc) begin
      qra_q  <= coord_ra_i;
      qdec_q <= coord_dec_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_match_o      = out_match_q;
  assign load_rejected_o = out_rej_q;
  assign entry_count_o   = ccm_pkg::ENTRY_CNT_W'(out_count_q);

  // Stage 1: absolute coordinate differences
  assign dr_d     = (qra_q >= rd_ra) ? (qra_q - rd_ra) : (rd_ra - qra_q);
  assign dec_diff = $signed({qdec_q[ccm_pkg::DEC_W-1], qdec_q}) -
                    $signed({rd_dec[ccm_pkg::DEC_W-1], rd_dec});
  assign dd_full  = dec_diff[ccm_pkg::DEC_W] ? ($unsigned(-dec_diff)) : $unsigned(dec_diff);

  // Stage 2: squares; stage 3 compare is combinational into hit_d
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      dr_q <= dr_d;
      dd_q <= dd_full[ccm_pkg::DEC_W-1:0];
    end
    if (s2_valid_q) begin
      sq_ra_q  <= ccm_pkg::SQ_RA_W'(dr_q) * ccm_pkg::SQ_RA_W'(dr_q);
      sq_dec_q <= ccm_pkg::SQ_DEC_W'(dd_q) * ccm_pkg::SQ_DEC_W'(dd_q);
    end
  end

  assign rsq   = ccm_pkg::RSQ_W'(sq_ra_q) + ccm_pkg::RSQ_W'(sq_dec_q);
  assign below = rsq < ccm_pkg::RSQ_W'(thr_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ccm_pkg::DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == ST_SCAN) && (issue_q < count_q))
    else $error("table read outside stored entries");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE) && !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("table write while a scan is in flight");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("query result taken before pipeline drained");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc) || $past(state_q == ST_DONE))
    else $error("result appeared without an item behind it");

endmodule
